[sv/memory_map_region_coalescer_defines.svh]
// ----------------------------------------------------------------------------
// Memory map region coalescer: assertion macros
// Shared macros for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef MEMORY_MAP_REGION_COALESCER_DEFINES_SVH
`define MEMORY_MAP_REGION_COALESCER_DEFINES_SVH

// check cons in the same cycle as ante, outside reset
`define MMRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmrc: implication check failed");

// check cons in the cycle after ante, outside reset
`define MMRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmrc: next-cycle check failed");

// check cons in the cycle after ante, reset included
`define MMRC_ASSERT_AFTER(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mmrc: reset check failed");

`endif

[sv/mmrc_pkg.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer: package
// Field widths, type codes, register indexes and the queue entry layout.
// ----------------------------------------------------------------------------
package mmrc_pkg;

   localparam int PageBytes  = 4096;
   localparam int QueueDepth = 2;

   localparam int TypeW     = 4;
   localparam int PhysW     = 52;
   localparam int VirtW     = 64;
   localparam int PagesW    = 40;
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 52;
   localparam int DataW     = 160;
   localparam int RspUserW  = TypeW + 1;

   localparam logic [TypeW-1:0] TypeReserved   = 4'd0;
   localparam logic [TypeW-1:0] TypeLoaderCode = 4'd1;
   localparam logic [TypeW-1:0] TypeFreeLow    = 4'd3;
   localparam logic [TypeW-1:0] TypeFree       = 4'd7;

   localparam logic [CsrIndexW-1:0] RegProtectLow  = 1'd0;
   localparam logic [CsrIndexW-1:0] RegProtectHigh = 1'd1;

   typedef struct packed {
      logic [PagesW-1:0] pages;
      logic [VirtW-1:0]  virt;
      logic [PhysW-1:0]  phys;
   } region_type;

   typedef struct packed {
      logic             a_valid;
      region_type       a;
      logic             b_valid;
      logic [TypeW-1:0] b_kind;
      region_type       b;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[sv/mmrc_front.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer: front end
// Accepts descriptors, checks the protected window, tracks the held free run
// and queues up to two results per descriptor.
// ----------------------------------------------------------------------------
module mmrc_front #(
   parameter int PAGE_BYTES = mmrc_pkg::PageBytes
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mmrc_pkg::TypeW-1:0]        req_kind,
   input  mmrc_pkg::region_type              req_region,
   input  logic                              req_last,
   input  logic                              csr_wr_en,
   input  logic [mmrc_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [mmrc_pkg::CsrDataW-1:0]     csr_wdata,
   input  mmrc_pkg::q_status_type            q_status,
   output logic                              q_push,
   output mmrc_pkg::entry_type               q_entry
);

   localparam int PageShift = $clog2(PAGE_BYTES);
   localparam int EndW      = mmrc_pkg::PagesW + PageShift + 1;

   logic [mmrc_pkg::PhysW-1:0] low_ff, low_in, high_ff, high_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_prot_ff, s1_prot_in;
   logic [mmrc_pkg::TypeW-1:0]   s1_kind_ff, s1_kind_in;
   mmrc_pkg::region_type         s1_region_ff, s1_region_in;
   logic                         s1_last_ff, s1_last_in;

   logic                         hold_valid_ff, hold_valid_in;
   mmrc_pkg::region_type         hold_ff, hold_in;

   logic                         accept, s1_adv, contig, is_free;
   logic [EndW-1:0]              hold_end;
   logic [mmrc_pkg::PagesW:0]    page_sum;
   logic [mmrc_pkg::PagesW-1:0]  merged_pages;
   mmrc_pkg::region_type         merged;
   mmrc_pkg::entry_type          ent;
   logic                         next_hold_valid;
   mmrc_pkg::region_type         next_hold;

   assign s1_adv     = s1_valid_ff && !q_status.full;
   assign req_tready = !s1_valid_ff || !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mmrc_pkg::RegProtectLow:  low_in  = csr_wdata;
            mmrc_pkg::RegProtectHigh: high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s1_prot_in   = accept ? ((req_region.phys > low_ff) && (req_region.phys < high_ff))
                                : s1_prot_ff;
   assign s1_kind_in   = accept ? req_kind : s1_kind_ff;
   assign s1_region_in = accept ? req_region : s1_region_ff;
   assign s1_last_in   = accept ? req_last : s1_last_ff;

   assign hold_end = EndW'(hold_ff.phys) + (EndW'(hold_ff.pages) << PageShift);
   assign contig   = hold_valid_ff && (EndW'(s1_region_ff.phys) == hold_end);
   assign page_sum = {1'b0, hold_ff.pages} + {1'b0, s1_region_ff.pages};
   assign merged_pages = page_sum[mmrc_pkg::PagesW] ? '1 : page_sum[mmrc_pkg::PagesW-1:0];
   assign is_free  = (s1_kind_ff >= mmrc_pkg::TypeFreeLow) && (s1_kind_ff <= mmrc_pkg::TypeFree);

   always_comb begin
      merged       = hold_ff;
      merged.pages = merged_pages;
   end

   always_comb begin
      ent             = '0;
      ent.last        = s1_last_ff;
      next_hold_valid = hold_valid_ff;
      next_hold       = hold_ff;
      priority if (s1_prot_ff) begin
         ent.a_valid     = hold_valid_ff;
         ent.a           = hold_ff;
         ent.b_valid     = 1'b1;
         ent.b_kind      = mmrc_pkg::TypeLoaderCode;
         ent.b           = s1_region_ff;
         next_hold_valid = 1'b0;
      end else if (s1_kind_ff == mmrc_pkg::TypeReserved) begin
         if (s1_last_ff) begin
            ent.a_valid     = hold_valid_ff;
            ent.a           = hold_ff;
            next_hold_valid = 1'b0;
         end
      end else if (is_free) begin
         if (contig) begin
            next_hold = merged;
            if (s1_last_ff) begin
               ent.b_valid     = 1'b1;
               ent.b_kind      = mmrc_pkg::TypeFree;
               ent.b           = merged;
               next_hold_valid = 1'b0;
            end
         end else begin
            ent.a_valid     = hold_valid_ff;
            ent.a           = hold_ff;
            next_hold_valid = !s1_last_ff;
            next_hold       = s1_region_ff;
            if (s1_last_ff) begin
               ent.b_valid = 1'b1;
               ent.b_kind  = mmrc_pkg::TypeFree;
               ent.b       = s1_region_ff;
            end
         end
      end else begin
         ent.a_valid     = hold_valid_ff;
         ent.a           = hold_ff;
         ent.b_valid     = 1'b1;
         ent.b_kind      = s1_kind_ff;
         ent.b           = s1_region_ff;
         next_hold_valid = 1'b0;
      end
   end

   assign hold_valid_in = s1_adv ? next_hold_valid : hold_valid_ff;
   assign hold_in       = s1_adv ? next_hold : hold_ff;
   assign q_push        = s1_adv && (ent.a_valid || ent.b_valid);
   assign q_entry       = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff        <= '0;
         high_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         low_ff        <= low_in;
         high_ff       <= high_in;
         s1_valid_ff   <= s1_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_prot_ff   <= s1_prot_in;
      s1_kind_ff   <= s1_kind_in;
      s1_region_ff <= s1_region_in;
      s1_last_ff   <= s1_last_in;
      hold_ff      <= hold_in;
   end

endmodule

[sv/mmrc_queue.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer: result queue
// Short queue of result entries between the front end and the back end.
// ----------------------------------------------------------------------------
module mmrc_queue #(
   parameter int QUEUE_DEPTH = mmrc_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mmrc_pkg::entry_type    push_entry,
   input  logic                   pop,
   output mmrc_pkg::entry_type    head,
   output mmrc_pkg::q_status_type status
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   mmrc_pkg::entry_type mem [QUEUE_DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full  = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem[rd_ptr_ff];

   assign wr_ptr_in = do_push ? ((wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? ((rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/mmrc_back.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer: back end
// Emits the results of each queued entry, one per cycle while the output is not
// stalled, through an output register.
// ----------------------------------------------------------------------------
module mmrc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mmrc_pkg::entry_type               head,
   input  mmrc_pkg::q_status_type            q_status,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mmrc_pkg::DataW-1:0]        rsp_tdata,
   output logic [mmrc_pkg::RspUserW-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);

   logic                               valid_ff, valid_in;
   logic                               a_done_ff, a_done_in;
   logic [mmrc_pkg::DataW-1:0]         data_ff, data_in;
   logic [mmrc_pkg::RspUserW-1:0]      user_ff, user_in;
   logic                               eom_ff, eom_in;
   logic                               load, sel_a;
   mmrc_pkg::region_type               region;
   logic [mmrc_pkg::TypeW-1:0]         kind;
   logic                               run_end;

   assign load   = !q_status.empty && (!valid_ff || rsp_tready);
   assign sel_a  = head.a_valid && !a_done_ff;
   assign region = sel_a ? head.a : head.b;
   assign kind   = sel_a ? mmrc_pkg::TypeFree : head.b_kind;
   assign run_end = !(sel_a && head.b_valid);
   assign q_pop  = load && run_end;

   assign a_done_in = load ? !run_end : a_done_ff;
   assign valid_in  = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   assign data_in   = load ? {(mmrc_pkg::DataW - $bits(mmrc_pkg::region_type))'(0), region}
                           : data_ff;
   assign user_in   = load ? {run_end, kind} : user_ff;
   assign eom_in    = load ? (run_end && head.last) : eom_ff;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = eom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         a_done_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         a_done_ff <= a_done_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      eom_ff  <= eom_in;
   end

endmodule

[sv/memory_map_region_coalescer.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer
// Cleans a firmware memory map: marks protected regions as loader code, drops
// reserved regions and merges contiguous free regions into single runs.
// ----------------------------------------------------------------------------
//  channel | direction | ports                    | payload
//  req     | in        | req_tvalid/tready        | tdata, tuser type, tlast end of map
//  rsp     | out       | rsp_tvalid/tready        | tdata, tuser type+run end, tlast
//  csr     | in        | csr_wr_en                | csr_index, csr_wdata
//
//  A descriptor is taken every cycle unless stage 1 is held by a full queue;
//  it gives zero to two results, which leave one at a time through the single
//  output register. The first result of an item passes the stage-1 register
//  and the queue before it is loaded into the output register.
//  Reset clears the held run, the queue and the protection bounds.
//  A stalled output fills the two-entry queue, then req_tready drops.
// ----------------------------------------------------------------------------
module memory_map_region_coalescer #(
   parameter int PAGE_BYTES  = mmrc_pkg::PageBytes,
   parameter int QUEUE_DEPTH = mmrc_pkg::QueueDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // phys_base[51:0], virt_base[115:52], page_count[155:116], zero pad
   input  logic [mmrc_pkg::DataW-1:0]        req_tdata,
   // type[3:0]
   input  logic [mmrc_pkg::TypeW-1:0]        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // phys_base[51:0], virt_base[115:52], page_count[155:116], zero pad
   output logic [mmrc_pkg::DataW-1:0]        rsp_tdata,
   // type[3:0], last_of_run[4]
   output logic [mmrc_pkg::RspUserW-1:0]     rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [mmrc_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [mmrc_pkg::CsrDataW-1:0]     csr_wdata
);

   mmrc_pkg::region_type   req_region;
   mmrc_pkg::entry_type    push_entry, head;
   mmrc_pkg::q_status_type q_status;
   logic                   q_push, q_pop;

   assign req_region = req_tdata[$bits(mmrc_pkg::region_type)-1:0];

   mmrc_front #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_region (req_region),
      .req_last   (req_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   mmrc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .status     (q_status)
   );

   mmrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sv/mmrc_checker.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer: port checker
// Checks on the result channel as seen at the top level's ports.
// ----------------------------------------------------------------------------
`include "memory_map_region_coalescer_defines.svh"

module mmrc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mmrc_pkg::RspUserW-1:0] rsp_tuser,
   input logic                          rsp_tlast
);

   `MMRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `MMRC_ASSERT_AFTER(a_rsp_idle_after_reset, clock, reset, !rsp_tvalid)
   `MMRC_ASSERT_IMPLY(a_eom_ends_run, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[mmrc_pkg::TypeW])
   `MMRC_ASSERT_IMPLY(a_flush_is_free, clock, reset, rsp_tvalid && !rsp_tuser[mmrc_pkg::TypeW], rsp_tuser[mmrc_pkg::TypeW-1:0] == mmrc_pkg::TypeFree)

endmodule

bind memory_map_region_coalescer mmrc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[verif/memory_map_region_coalescer_test.sv]
// ----------------------------------------------------------------------------
// Memory map region coalescer: block-level testbench
// Streams firmware memory descriptors through the coalescer, models the held
// free run and the protection window alongside it, and compares every cleaned
// map item with the modelled one. Directed cases cover merging, saturation,
// address wrap and the window bounds; random maps follow under three idling
// patterns and several window settings.
// ----------------------------------------------------------------------------
module memory_map_region_coalescer_test;
   import mmrc_pkg::*;

   localparam logic [PhysW-1:0]  PhysMax  = '1;
   localparam logic [PagesW-1:0] PagesMax = '1;

   typedef struct packed {
      logic [TypeW-1:0]  kind;
      logic [PhysW-1:0]  phys;
      logic [VirtW-1:0]  virt;
      logic [PagesW-1:0] pages;
      logic              run_end;
      logic              map_end;
   } map_region_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DataW-1:0]     req_tdata = '0;
   logic [TypeW-1:0]     req_tuser = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DataW-1:0]     rsp_tdata;
   logic [RspUserW-1:0]  rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_wr_en = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   int snd_idle_pct = 20;
   int rsp_idle_pct = 66;
   int errors = 0;

   logic [PhysW-1:0]  prot_low = '0;
   logic [PhysW-1:0]  prot_high = '0;
   logic              held = 1'b0;
   logic [PhysW-1:0]  held_phys = '0;
   logic [VirtW-1:0]  held_virt = '0;
   logic [PagesW-1:0] held_pages = '0;

   map_region_type step_out [2];
   int             step_n;
   map_region_type cleaned_map [$];

   memory_map_region_coalescer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("memory_map_region_coalescer: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   function automatic map_region_type make_region(input logic [TypeW-1:0] kind,
                                                  input logic [PhysW-1:0] phys,
                                                  input logic [VirtW-1:0] virt,
                                                  input logic [PagesW-1:0] pages);
      map_region_type r;
      r.kind    = kind;
      r.phys    = phys;
      r.virt    = virt;
      r.pages   = pages;
      r.run_end = 1'b0;
      r.map_end = 1'b0;
      return r;
   endfunction

   function void flush_held();
      if (held) begin
         step_out[step_n] = make_region(TypeFree, held_phys, held_virt, held_pages);
         step_n++;
         held = 1'b0;
      end
   endfunction

   function void coalesce_descriptor(input logic [TypeW-1:0] kind,
                                     input logic [PhysW-1:0] phys,
                                     input logic [VirtW-1:0] virt,
                                     input logic [PagesW-1:0] pages,
                                     input logic last);
      logic [95:0]     run_limit;
      logic [PagesW:0] sum;
      step_n = 0;
      if (phys > prot_low && phys < prot_high) begin
         flush_held();
         step_out[step_n] = make_region(TypeLoaderCode, phys, virt, pages);
         step_n++;
      end else if (kind == TypeReserved) begin
         // drop, leave the run open
      end else if (kind >= TypeFreeLow && kind <= TypeFree) begin
         run_limit = 96'(held_phys) + 96'(held_pages) * 96'(PageBytes);
         if (held && 96'(phys) == run_limit) begin
            sum = {1'b0, held_pages} + {1'b0, pages};
            held_pages = sum[PagesW] ? PagesMax : sum[PagesW-1:0];
         end else begin
            flush_held();
            held       = 1'b1;
            held_phys  = phys;
            held_virt  = virt;
            held_pages = pages;
         end
      end else begin
         flush_held();
         step_out[step_n] = make_region(kind, phys, virt, pages);
         step_n++;
      end
      if (last)
         flush_held();
      if (step_n > 0) begin
         step_out[step_n-1].run_end = 1'b1;
         step_out[step_n-1].map_end = last;
      end
      for (int i = 0; i < step_n; i++)
         cleaned_map.push_back(step_out[i]);
   endfunction

   function void check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      map_region_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cleaned_map.size() == 0) begin
            $display("%0t: no item expected, got type %0h phys %0h", $time,
                     rsp_tuser[TypeW-1:0], rsp_tdata[PhysW-1:0]);
            errors++;
         end else begin
            want = cleaned_map.pop_front();
            check_field("type", 64'(want.kind), 64'(rsp_tuser[TypeW-1:0]));
            check_field("phys_base", 64'(want.phys), 64'(rsp_tdata[PhysW-1:0]));
            check_field("virt_base", want.virt, rsp_tdata[PhysW+VirtW-1:PhysW]);
            check_field("page_count", 64'(want.pages),
                        64'(rsp_tdata[PhysW+VirtW+PagesW-1:PhysW+VirtW]));
            check_field("last_of_run", 64'(want.run_end), 64'(rsp_tuser[TypeW]));
            check_field("end_of_map", 64'(want.map_end), 64'(rsp_tlast));
         end
      end
   end

   task automatic send_item(input logic [TypeW-1:0] kind,
                            input logic [PhysW-1:0] phys,
                            input logic [VirtW-1:0] virt,
                            input logic [PagesW-1:0] pages,
                            input logic last);
      if ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DataW'({pages, virt, phys});
      req_tuser  <= kind;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      coalesce_descriptor(kind, phys, virt, pages, last);
   endtask

   task automatic program_reg(input logic [CsrIndexW-1:0] index,
                              input logic [CsrDataW-1:0] value);
      req_tvalid <= 1'b0;
      while (cleaned_map.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == RegProtectLow)
         prot_low = value;
      else
         prot_high = value;
   endtask

   task automatic test_merge_runs();
      send_item(TypeFree, 52'h1000, 64'h0, 40'd1, 1'b0);
      send_item(4'd3, 52'h2000, 64'hFFFF_FFFF_FFFF_FFFF, 40'd2, 1'b0);
      send_item(TypeReserved, 52'h4000, 64'h1234, 40'd9, 1'b0);
      send_item(4'd5, 52'h4000, 64'h5555, PagesMax, 1'b0);
      send_item(4'd6, 52'h8_0000, 64'hAAAA_0000, 40'd4, 1'b0);
      send_item(4'd2, 52'h9_0000, 64'h77, 40'd0, 1'b0);
      send_item(4'd15, PhysMax, 64'hFFFF_FFFF_FFFF_FFFF, PagesMax, 1'b1);
      send_item(TypeReserved, 52'h0, 64'h0, 40'd0, 1'b1);
   endtask

   task automatic test_address_wrap();
      logic [PhysW-1:0] wrapped;
      wrapped = PhysMax + (PhysW'(PagesMax) << 12);
      send_item(4'd4, PhysMax, 64'h8000_0000_0000_0000, PagesMax, 1'b0);
      send_item(TypeFree, wrapped, 64'h1, 40'd3, 1'b0);
      send_item(4'd8, 52'h0, 64'h2, 40'd1, 1'b1);
      send_item(4'd4, 52'h0, 64'h3, 40'd0, 1'b1);
   endtask

   task automatic test_protection_window();
      program_reg(RegProtectLow, 52'h1_0000);
      program_reg(RegProtectHigh, 52'h2_0000);
      send_item(TypeFree, 52'h3_0000, 64'h10, 40'd1, 1'b0);
      send_item(TypeReserved, 52'h1_8000, 64'h11, 40'd2, 1'b0);
      send_item(4'd9, 52'h1_0000, 64'h12, 40'd3, 1'b0);
      send_item(4'd3, 52'h2_0000, 64'h13, 40'd3, 1'b0);
      send_item(TypeLoaderCode, 52'h1_1000, 64'h14, 40'd5, 1'b1);
      send_item(TypeLoaderCode, 52'h4_0000, 64'h15, 40'd6, 1'b1);
   endtask

   task automatic test_random_maps();
      logic [PhysW-1:0]  win_low  [6];
      logic [PhysW-1:0]  win_high [6];
      logic [PhysW-1:0]  cursor;
      logic [PhysW-1:0]  phys;
      logic [VirtW-1:0]  virt;
      logic [PagesW-1:0] pages;
      logic [TypeW-1:0]  kind;
      logic [63:0]       span;
      int                pick;
      int                other;
      win_low  = '{52'h10_0000, 52'h0, PhysMax, PhysMax, 52'h10_0000, PhysMax};
      win_high = '{52'h40_0000, PhysMax, PhysMax, 52'h0, 52'h40_0000, PhysMax};
      win_low[2]  = PhysW'({$urandom, $urandom});
      win_high[2] = PhysW'({$urandom, $urandom});
      for (int blk = 0; blk < 6; blk++) begin
         program_reg(RegProtectLow, win_low[blk]);
         program_reg(RegProtectHigh, win_high[blk]);
         snd_idle_pct = (blk < 2) ? 20 : (blk < 4) ? 66 : 0;
         rsp_idle_pct = (blk < 2) ? 66 : (blk < 4) ? 20 : 0;
         cursor = PhysW'($urandom_range(0, 32'h3FF)) << 12;
         for (int n = 0; n < 190; n++) begin
            pick  = $urandom_range(0, 99);
            virt  = {$urandom, $urandom};
            phys  = PhysW'({$urandom, $urandom});
            kind  = TypeW'($urandom_range(0, 15));
            pages = ($urandom_range(0, 99) < 8) ? PagesW'({$urandom, $urandom})
                                                : PagesW'($urandom_range(0, 15));
            if (pick < 45) begin
               kind = TypeW'($urandom_range(TypeFreeLow, TypeFree));
               phys = cursor;
            end else if (pick < 55) begin
               kind = TypeW'($urandom_range(TypeFreeLow, TypeFree));
            end else if (pick < 63) begin
               kind = TypeReserved;
               if (pick < 59)
                  phys = cursor;
            end else if (pick < 73) begin
               other = $urandom_range(0, 9);
               kind  = (other == 8) ? TypeLoaderCode :
                       (other == 9) ? 4'd2 : TypeW'(8 + other);
            end else if (pick < 85) begin
               if ({1'b0, prot_high} > {1'b0, prot_low} + 53'd1) begin
                  span = 64'(prot_high) - 64'(prot_low) - 64'd1;
                  phys = prot_low + 52'd1 + PhysW'({$urandom, $urandom} % span);
               end
            end
            if (kind >= TypeFreeLow && kind <= TypeFree)
               cursor = phys + (PhysW'(pages) << 12);
            if ($urandom_range(0, 99) < 5)
               cursor = PhysW'($urandom_range(0, 32'h3FF)) << 12;
            send_item(kind, phys, virt, pages, $urandom_range(0, 11) == 0);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_merge_runs();
      test_address_wrap();
      test_protection_window();
      test_random_maps();
      req_tvalid <= 1'b0;
      while (cleaned_map.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("memory_map_region_coalescer: match");
      else
         $display("memory_map_region_coalescer: mismatch");
      $finish;
   end

endmodule
